@@ hw/rtl/gpc_pkg.sv @@
`timescale 1ns / 1ps

package gpc_pkg;

	localparam int MAX_ROWS      = 1024;
	localparam int MAX_SUCCESSES = 5;

	localparam int ADDR_W    = $clog2(MAX_ROWS);
	localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
	localparam int SUCC_W    = $clog2(MAX_SUCCESSES + 1);

	localparam int ROW_W   = 64;
	localparam int TRIAL_W = 63;
	localparam int VW_W    = 7;
	localparam int RC_W    = 11;
	localparam int IDX_W   = 10;
	localparam int DATA_W  = 64;
	localparam int PADDR_W = 5;

	localparam logic [ROW_W-1:0] GEN_C0 = 64'h9E3779B97F4A7C15;
	localparam logic [ROW_W-1:0] GEN_C1 = 64'hBF58476D1CE4E5B9;
	localparam int GEN_SH_A = 23;
	localparam int GEN_SH_B = 18;
	localparam int GEN_SH_C = 5;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_ROW_COUNT    = 2'd0;
	localparam reg_idx_t REG_VECTOR_WIDTH = 2'd1;
	localparam reg_idx_t REG_TRIAL_LIMIT  = 2'd2;
	localparam reg_idx_t REG_SEED_VALUE   = 2'd3;

	typedef struct packed {
		logic [RC_W-1:0]    row_count;
		logic [VW_W-1:0]    vector_width;
		logic [TRIAL_W-1:0] trial_limit;
		logic [ROW_W-1:0]   seed_value;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ROW_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [ROW_W-1:0] gen_mask(input logic [VW_W-1:0] vw);
		logic [ROW_W-1:0] m;
		if (vw == '0) begin
			m = '0;
		end else if (32'(vw) >= ROW_W) begin
			m = '1;
		end else begin
			m = (ROW_W'(1) << vw) - ROW_W'(1);
		end
		return m;
	endfunction

	function automatic logic [ROW_CNT_W-1:0] sat_rows(input logic [RC_W-1:0] rc);
		logic [ROW_CNT_W-1:0] r;
		if (32'(rc) > 32'(MAX_ROWS)) begin
			r = ROW_CNT_W'(MAX_ROWS);
		end else begin
			r = ROW_CNT_W'(rc);
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/gpc_if.sv @@
`timescale 1ns / 1ps

interface gpc_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [gpc_pkg::IDX_W-1:0]   row_index;
	logic [gpc_pkg::ROW_W-1:0]   row_bits;

	modport source(output valid, kind, row_index, row_bits, input ready);
	modport sink(input valid, kind, row_index, row_bits, output ready);
endinterface

interface gpc_res_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [gpc_pkg::TRIAL_W-1:0] trial_number;
	logic [gpc_pkg::ROW_W-1:0]   vector_one;
	logic [gpc_pkg::ROW_W-1:0]   vector_two;
	logic [gpc_pkg::ROW_W-1:0]   vector_three;
	logic                        last_result;

	modport source(output valid, found, trial_number, vector_one, vector_two, vector_three,
		last_result, input ready);
	modport sink(input valid, found, trial_number, vector_one, vector_two, vector_three,
		last_result, output ready);
endinterface

@@ hw/rtl/gpc_cfg.sv @@
`timescale 1ns / 1ps

module gpc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gpc_pkg::PADDR_W-1:0]  paddr,
	input  logic [gpc_pkg::DATA_W-1:0]   pwdata,
	output logic [gpc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output gpc_pkg::cfg_t                cfg
);

	gpc_pkg::cfg_t    cfg_q;
	gpc_pkg::reg_idx_t idx;
	logic             wr;

	assign idx    = paddr[4:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count    <= gpc_pkg::RC_W'(1);
			cfg_q.vector_width <= gpc_pkg::VW_W'(64);
			cfg_q.trial_limit  <= '0;
			cfg_q.seed_value   <= gpc_pkg::ROW_W'(1);
		end else if (wr) begin
			case (idx)
				gpc_pkg::REG_ROW_COUNT:    cfg_q.row_count    <= pwdata[gpc_pkg::RC_W-1:0];
				gpc_pkg::REG_VECTOR_WIDTH: cfg_q.vector_width <= pwdata[gpc_pkg::VW_W-1:0];
				gpc_pkg::REG_TRIAL_LIMIT:  cfg_q.trial_limit  <= pwdata[gpc_pkg::TRIAL_W-1:0];
				gpc_pkg::REG_SEED_VALUE:   cfg_q.seed_value   <= pwdata[gpc_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			gpc_pkg::REG_ROW_COUNT:    prdata = gpc_pkg::DATA_W'(cfg_q.row_count);
			gpc_pkg::REG_VECTOR_WIDTH: prdata = gpc_pkg::DATA_W'(cfg_q.vector_width);
			gpc_pkg::REG_TRIAL_LIMIT:  prdata = gpc_pkg::DATA_W'(cfg_q.trial_limit);
			gpc_pkg::REG_SEED_VALUE:   prdata = gpc_pkg::DATA_W'(cfg_q.seed_value);
			default:                   prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/gpc_rowmem.sv @@
`timescale 1ns / 1ps

module gpc_rowmem (
	input  logic                       clk,
	input  gpc_pkg::mem_req_t          req,
	output logic [gpc_pkg::ROW_W-1:0]  rdata
);

	logic [gpc_pkg::ROW_W-1:0] mem [gpc_pkg::MAX_ROWS];
	logic [gpc_pkg::ROW_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/gpc_search.sv @@
`timescale 1ns / 1ps

module gpc_search (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gpc_pkg::cfg_t              cfg,
	gpc_cmd_if.sink                    cmd,
	gpc_res_if.source                  res,
	output gpc_pkg::mem_req_t          mem_req,
	input  logic [gpc_pkg::ROW_W-1:0]  mem_rdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_GEN   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_HIT   = 3'd3;
	localparam logic [2:0] ST_NEXT  = 3'd4;
	localparam logic [2:0] ST_FINAL = 3'd5;

	logic [2:0]                      state_q;
	logic [1:0]                      gen_cnt_q;
	logic [gpc_pkg::TRIAL_W-1:0]     trial_q;
	logic [gpc_pkg::SUCC_W-1:0]      succ_q;
	logic [gpc_pkg::ROW_CNT_W-1:0]   ptr_q;
	logic                            chk_s1;
	logic                            chk_last_s1;
	logic                            pend_valid_q;
	logic                            out_valid_q;

	logic [gpc_pkg::ROW_W-1:0]       w0_q, w1_q;
	logic [gpc_pkg::ROW_W-1:0]       va_q, vb_q, vc_q;
	logic [gpc_pkg::TRIAL_W-1:0]     pend_trial_q;
	logic [gpc_pkg::ROW_W-1:0]       pend_a_q, pend_b_q, pend_c_q;
	logic                            out_found_q;
	logic                            out_last_q;
	logic [gpc_pkg::TRIAL_W-1:0]     out_trial_q;
	logic [gpc_pkg::ROW_W-1:0]       out_a_q, out_b_q, out_c_q;

	logic                            cmd_acc;
	logic                            search_go;
	logic [gpc_pkg::ROW_CNT_W-1:0]   rows;
	logic [gpc_pkg::ROW_W-1:0]       mask;
	logic [gpc_pkg::ROW_W-1:0]       gx, w1_nx, draw;
	logic                            syn_zero;
	logic                            issue;
	logic                            out_free;
	logic                            hit_go;
	logic                            succ_done;
	logic                            trial_done;
	logic                            load_hit;
	logic                            load_final;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_acc    = cmd.valid && cmd.ready;
	assign search_go  = cmd_acc && cmd.kind;

	assign rows = gpc_pkg::sat_rows(cfg.row_count);
	assign mask = gpc_pkg::gen_mask(cfg.vector_width);

	// xorshift128+ step
	assign gx    = w0_q ^ (w0_q << gpc_pkg::GEN_SH_A);
	assign w1_nx = gx ^ w1_q ^ (gx >> gpc_pkg::GEN_SH_B) ^ (w1_q >> gpc_pkg::GEN_SH_C);
	assign draw  = (w1_nx + w1_q) & mask;

	assign syn_zero = !(^(mem_rdata & va_q)) && !(^(mem_rdata & vb_q))
		&& !(^(mem_rdata & vc_q));

	// stop issuing reads once the current row decides the trial
	assign issue = (state_q == ST_SCAN) && !(chk_s1 && (syn_zero || chk_last_s1))
		&& (ptr_q < rows);

	assign out_free   = !out_valid_q || res.ready;
	assign hit_go     = !pend_valid_q || out_free;
	assign succ_done  = (32'(succ_q) + 32'd1) >= 32'(gpc_pkg::MAX_SUCCESSES);
	assign trial_done = (trial_q + gpc_pkg::TRIAL_W'(1)) >= cfg.trial_limit;
	assign load_hit   = (state_q == ST_HIT) && pend_valid_q && out_free;
	assign load_final = (state_q == ST_FINAL) && out_free;

	always_comb begin
		mem_req.we    = cmd_acc && !cmd.kind && (32'(cmd.row_index) < 32'(gpc_pkg::MAX_ROWS));
		mem_req.waddr = gpc_pkg::ADDR_W'(cmd.row_index);
		mem_req.wdata = cmd.row_bits;
		mem_req.re    = issue;
		mem_req.raddr = ptr_q[gpc_pkg::ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			gen_cnt_q    <= '0;
			trial_q      <= '0;
			succ_q       <= '0;
			ptr_q        <= '0;
			chk_s1       <= 1'b0;
			chk_last_s1  <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_hit || load_final) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (search_go) begin
						trial_q      <= '0;
						succ_q       <= '0;
						pend_valid_q <= 1'b0;
						gen_cnt_q    <= '0;
						state_q      <= (cfg.trial_limit == '0) ? ST_FINAL : ST_GEN;
					end
				end
				ST_GEN: begin
					if (gen_cnt_q == 2'd2) begin
						gen_cnt_q <= '0;
						ptr_q     <= '0;
						chk_s1    <= 1'b0;
						state_q   <= (rows == '0) ? ST_HIT : ST_SCAN;
					end else begin
						gen_cnt_q <= gen_cnt_q + 2'd1;
					end
				end
				ST_SCAN: begin
					if (chk_s1 && syn_zero) begin
						chk_s1  <= 1'b0;
						state_q <= ST_NEXT;
					end else if (chk_s1 && chk_last_s1) begin
						chk_s1  <= 1'b0;
						state_q <= ST_HIT;
					end else if (issue) begin
						chk_s1      <= 1'b1;
						chk_last_s1 <= (ptr_q + gpc_pkg::ROW_CNT_W'(1)) == rows;
						ptr_q       <= ptr_q + gpc_pkg::ROW_CNT_W'(1);
					end else begin
						chk_s1 <= 1'b0;
					end
				end
				ST_HIT: begin
					// hold until the previous success can move to the output
					if (hit_go) begin
						pend_valid_q <= 1'b1;
						succ_q       <= succ_q + gpc_pkg::SUCC_W'(1);
						state_q      <= succ_done ? ST_FINAL : ST_NEXT;
					end
				end
				ST_NEXT: begin
					trial_q <= trial_q + gpc_pkg::TRIAL_W'(1);
					state_q <= trial_done ? ST_FINAL : ST_GEN;
				end
				ST_FINAL: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (search_go) begin
			w0_q <= gpc_pkg::GEN_C0 ^ cfg.seed_value;
			w1_q <= gpc_pkg::GEN_C1;
		end else if (state_q == ST_GEN) begin
			w0_q <= w1_q;
			w1_q <= w1_nx;
			case (gen_cnt_q)
				2'd0:    va_q <= draw;
				2'd1:    vb_q <= draw;
				default: vc_q <= draw;
			endcase
		end

		if ((state_q == ST_HIT) && hit_go) begin
			pend_trial_q <= trial_q;
			pend_a_q     <= va_q;
			pend_b_q     <= vb_q;
			pend_c_q     <= vc_q;
		end

		if (load_hit) begin
			out_found_q <= 1'b1;
			out_last_q  <= 1'b0;
			out_trial_q <= pend_trial_q;
			out_a_q     <= pend_a_q;
			out_b_q     <= pend_b_q;
			out_c_q     <= pend_c_q;
		end else if (load_final) begin
			out_found_q <= pend_valid_q;
			out_last_q  <= 1'b1;
			out_trial_q <= pend_valid_q ? pend_trial_q : '0;
			out_a_q     <= pend_valid_q ? pend_a_q : '0;
			out_b_q     <= pend_valid_q ? pend_b_q : '0;
			out_c_q     <= pend_valid_q ? pend_c_q : '0;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.found        = out_found_q;
	assign res.trial_number = out_trial_q;
	assign res.vector_one   = out_a_q;
	assign res.vector_two   = out_b_q;
	assign res.vector_three = out_c_q;
	assign res.last_result  = out_last_q;

endmodule

@@ hw/rtl/gf2_parity_cover_random_search_top.sv @@
`timescale 1ns / 1ps

// GF(2) parity cover random search. A load beat (kind 0) writes one 64-bit row into the
// 1024-entry row store. A search beat (kind 1) reseeds a xorshift128+ generator from
// seed_value and runs up to trial_limit trials; each trial draws three masked vectors,
// then reads the stored rows through the single read port of the row store, one row per
// cycle, and stops at the first row whose 3-bit parity syndrome is zero. Every success
// yields one result beat with the trial number and vectors; the search ends after five
// successes or when the trial limit runs out, and a search without success yields a
// single not-found beat. The final beat of a search carries last_result. No new beat is
// accepted while a search runs. Registers (64-bit APB, byte address 8*i): row_count,
// vector_width, trial_limit, seed_value. The row store has no reset; rows read by a
// search must be loaded first.
module gf2_parity_cover_random_search_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gpc_pkg::PADDR_W-1:0]  paddr,
	input  logic [gpc_pkg::DATA_W-1:0]   pwdata,
	output logic [gpc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	gpc_cmd_if.sink                      cmd,
	gpc_res_if.source                    res
);

	gpc_pkg::cfg_t              cfg;
	gpc_pkg::mem_req_t          mem_req;
	logic [gpc_pkg::ROW_W-1:0]  mem_rdata;

	gpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gpc_rowmem u_rowmem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	gpc_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam bit KIND_LOAD   = 1'b0;
	localparam bit KIND_SEARCH = 1'b1;

	localparam int ROW_SLOTS      = 1024;
	localparam int FILL_ROWS      = 64;
	localparam int BLOCK_ROW      = 40;
	localparam int COVER_CAP      = 5;
	localparam int RANDOM_ITEMS   = 360;
	localparam int SETTLE_CYCLES  = 12;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 100000;

	localparam logic [63:0] SEED_MIX = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] SEED_FIX = 64'hBF58476D1CE4E5B9;

	typedef struct packed {
		logic        found;
		logic [62:0] trial_number;
		logic [63:0] vector_one;
		logic [63:0] vector_two;
		logic [63:0] vector_three;
		logic        last_result;
	} beat_t;

	localparam beat_t NOT_FOUND = '{found: 1'b0, trial_number: '0, vector_one: '0,
		vector_two: '0, vector_three: '0, last_result: 1'b1};

	typedef struct {
		bit            new_regs;
		gpc_pkg::cfg_t regs;
		bit            kind;
		logic [9:0]    row_index;
		logic [63:0]   row_bits;
		bit            typed;
		beat_t         want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [gpc_pkg::PADDR_W-1:0] paddr;
	logic [gpc_pkg::DATA_W-1:0]  pwdata;
	logic [gpc_pkg::DATA_W-1:0]  prdata;
	logic pready;

	gpc_cmd_if cmd_ch();
	gpc_res_if res_ch();

	gf2_parity_cover_random_search_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [63:0]   row_mirror [0:ROW_SLOTS-1];
	logic [63:0]   gen_s0;
	logic [63:0]   gen_s1;
	gpc_pkg::cfg_t live_regs;
	beat_t         covers_due[$];
	step_t         directed_steps[$];
	int            mismatches = 0;
	bit            calm = 1'b0;
	int            stall_left = 0;

	function automatic void compare(string what, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [63:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] draw_word();
		logic [63:0] x;
		logic [63:0] y;
		x = gen_s0;
		y = gen_s1;
		gen_s0 = y;
		x = x ^ (x << 23);
		gen_s1 = x ^ y ^ (x >> 18) ^ (y >> 5);
		return gen_s1 + y;
	endfunction

	// Run one search on the mirrored rows and queue the beats it should produce.
	function automatic void find_covers();
		logic [63:0] mask;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] r;
		logic [10:0] nrows;
		logic [62:0] t;
		beat_t held;
		bit have;
		bit ok;
		int hits;
		if (live_regs.vector_width == '0)
			mask = '0;
		else if (live_regs.vector_width >= 7'd64)
			mask = '1;
		else
			mask = (64'd1 << live_regs.vector_width) - 64'd1;
		nrows = (live_regs.row_count > 11'(ROW_SLOTS)) ? 11'(ROW_SLOTS) : live_regs.row_count;
		gen_s0 = SEED_MIX ^ live_regs.seed_value;
		gen_s1 = SEED_FIX;
		have = 1'b0;
		hits = 0;
		held = NOT_FOUND;
		for (t = '0; t < live_regs.trial_limit && hits < COVER_CAP; t++) begin
			a = draw_word() & mask;
			b = draw_word() & mask;
			c = draw_word() & mask;
			ok = 1'b1;
			for (int i = 0; i < int'(nrows) && ok; i++) begin
				r = row_mirror[i];
				if (!(^(r & a)) && !(^(r & b)) && !(^(r & c)))
					ok = 1'b0;
			end
			if (ok) begin
				if (have)
					covers_due.push_back(held);
				held = '{1'b1, t, a, b, c, 1'b0};
				have = 1'b1;
				hits++;
			end
		end
		if (have) begin
			held.last_result = 1'b1;
			covers_due.push_back(held);
		end else begin
			covers_due.push_back(NOT_FOUND);
		end
	endfunction

	function automatic gpc_pkg::cfg_t make_regs(logic [10:0] rc, logic [6:0] vw,
		logic [62:0] tl, logic [63:0] seed);
		gpc_pkg::cfg_t c;
		c.row_count    = rc;
		c.vector_width = vw;
		c.trial_limit  = tl;
		c.seed_value   = seed;
		return c;
	endfunction

	function automatic void load_step(logic [9:0] idx, logic [63:0] bits);
		step_t s;
		s.new_regs  = 1'b0;
		s.regs      = live_regs;
		s.kind      = KIND_LOAD;
		s.row_index = idx;
		s.row_bits  = bits;
		s.typed     = 1'b0;
		s.want      = NOT_FOUND;
		directed_steps.push_back(s);
	endfunction

	function automatic void search_step(bit new_regs, gpc_pkg::cfg_t regs, bit typed,
		beat_t want);
		step_t s;
		s.new_regs  = new_regs;
		s.regs      = regs;
		s.kind      = KIND_SEARCH;
		s.row_index = '0;
		s.row_bits  = '0;
		s.typed     = typed;
		s.want      = want;
		directed_steps.push_back(s);
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] row_content();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return '0;
		if (roll < 12)
			return '1;
		if (roll < 22)
			return 64'd1 << $urandom_range(0, 63);
		return wide_random();
	endfunction

	function automatic gpc_pkg::cfg_t rand_regs();
		gpc_pkg::cfg_t c;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			c.row_count = '0;
		else if (roll < 80)
			c.row_count = 11'($urandom_range(1, 8));
		else if (roll < 95)
			c.row_count = 11'($urandom_range(9, 24));
		else
			c.row_count = 11'($urandom_range(25, 64));
		roll = $urandom_range(0, 99);
		if (roll < 55)
			c.vector_width = 7'd64;
		else if (roll < 85)
			c.vector_width = 7'($urandom_range(1, 63));
		else if (roll < 92)
			c.vector_width = '0;
		else
			c.vector_width = 7'($urandom_range(65, 127));
		roll = $urandom_range(0, 99);
		if (roll < 8)
			c.trial_limit = '0;
		else if (roll < 15)
			c.trial_limit = 63'd1;
		else if (roll < 90)
			c.trial_limit = 63'($urandom_range(2, 30));
		else if (c.row_count == '0)
			c.trial_limit = 63'(wide_random());
		else
			c.trial_limit = 63'($urandom_range(31, 120));
		c.seed_value = wide_random();
		return c;
	endfunction

	task automatic write_reg(input gpc_pkg::reg_idx_t idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= gpc_pkg::PADDR_W'({idx, 3'b000});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// read it back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		compare("register readback", value, prdata);
	endtask

	// Drain the block before touching any register.
	task automatic program_regs(input gpc_pkg::cfg_t c);
		cmd_ch.valid <= 1'b0;
		while (covers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(gpc_pkg::REG_ROW_COUNT, 64'(c.row_count));
		write_reg(gpc_pkg::REG_VECTOR_WIDTH, 64'(c.vector_width));
		write_reg(gpc_pkg::REG_TRIAL_LIMIT, 64'(c.trial_limit));
		write_reg(gpc_pkg::REG_SEED_VALUE, c.seed_value);
		psel    <= 1'b0;
		penable <= 1'b0;
		live_regs = c;
	endtask

	task automatic push_cmd(input bit kind, input logic [9:0] idx, input logic [63:0] bits,
		input bit typed = 1'b0, input beat_t want = NOT_FOUND);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.kind      <= kind;
		cmd_ch.row_index <= idx;
		cmd_ch.row_bits  <= bits;
		do @(posedge clk); while (!cmd_ch.ready);
		if (kind == KIND_LOAD)
			row_mirror[idx] = bits;
		else if (typed)
			covers_due.push_back(want);
		else
			find_covers();
	endtask

	always @(posedge clk) begin
		int roll;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (calm || roll < 60) begin
				res_ch.ready <= 1'b1;
				stall_left   <= $urandom_range(0, 8);
			end else if (roll < 95) begin
				res_ch.ready <= 1'b0;
				stall_left   <= $urandom_range(0, 3);
			end else begin
				res_ch.ready <= 1'b0;
				stall_left   <= $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		beat_t got;
		beat_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got = '{res_ch.found, res_ch.trial_number, res_ch.vector_one, res_ch.vector_two,
				res_ch.vector_three, res_ch.last_result};
			if (covers_due.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, got %h", $time, got);
				mismatches++;
			end else begin
				want = covers_due.pop_front();
				compare("found", 64'(want.found), 64'(got.found));
				compare("trial_number", 64'(want.trial_number), 64'(got.trial_number));
				compare("vector_one", want.vector_one, got.vector_one);
				compare("vector_two", want.vector_two, got.vector_two);
				compare("vector_three", want.vector_three, got.vector_three);
				compare("last_result", 64'(want.last_result), 64'(got.last_result));
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
				|| (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				|| (psel === 1'b1 && penable === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		gpc_pkg::cfg_t phase_regs;
		int            phase_len;
		int            roll;
		int            random_items;
		logic [63:0]   fill_word;

		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.kind      <= KIND_LOAD;
		cmd_ch.row_index <= '0;
		cmd_ch.row_bits  <= '0;
		live_regs = make_regs(11'd1, 7'd64, 63'd0, 64'd1);

		// Rows 0..3: all ones, lsb only, msb only, zero.
		load_step(10'd0, '1);
		load_step(10'd1, 64'd1);
		load_step(10'd2, 64'h8000_0000_0000_0000);
		load_step(10'd3, '0);
		search_step(1'b0, live_regs, 1'b1, NOT_FOUND);
		search_step(1'b1, make_regs(11'd0, 7'd0, '1, 64'd0), 1'b0, NOT_FOUND);
		search_step(1'b1, make_regs(11'd1, 7'd64, 63'd40, '1), 1'b0, NOT_FOUND);
		search_step(1'b1, make_regs(11'd3, 7'd1, 63'd25, 64'd1), 1'b1, NOT_FOUND);
		search_step(1'b1, make_regs(11'd3, 7'd127, 63'd30, 64'd5), 1'b0, NOT_FOUND);
		search_step(1'b1, make_regs(11'd3, 7'd63, 63'd20, 64'd9), 1'b1, NOT_FOUND);
		search_step(1'b1, make_regs(11'd4, 7'd64, 63'd20, 64'd3), 1'b1, NOT_FOUND);
		search_step(1'b1, make_regs(11'd2, 7'd64, 63'd1, wide_random()), 1'b0, NOT_FOUND);
		load_step(10'd1023, 64'h5555_5555_5555_5555);
		load_step(10'd0, 64'hAAAA_AAAA_AAAA_AAAA);
		search_step(1'b1, make_regs(11'd1, 7'd2, 63'd50, 64'd0), 1'b0, NOT_FOUND);
		search_step(1'b1, make_regs(11'd2, 7'd64, 63'd30, 64'd7), 1'b0, NOT_FOUND);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].new_regs)
				program_regs(directed_steps[i].regs);
			push_cmd(directed_steps[i].kind, directed_steps[i].row_index,
				directed_steps[i].row_bits, directed_steps[i].typed, directed_steps[i].want);
		end

		// Fill the rows the random phases can reach with one value so searches can succeed.
		fill_word = wide_random() | 64'd1;
		for (int i = 0; i < FILL_ROWS; i++)
			push_cmd(KIND_LOAD, 10'(i), fill_word);
		program_regs(make_regs(11'(FILL_ROWS), 7'd64, 63'd6, wide_random()));
		push_cmd(KIND_SEARCH, 10'($urandom), wide_random());
		// A zero row kills every trial before the scan leaves the loaded rows.
		push_cmd(KIND_LOAD, 10'(BLOCK_ROW), '0);
		program_regs(make_regs(11'd2047, 7'd1, 63'd6, wide_random()));
		push_cmd(KIND_SEARCH, 10'($urandom), wide_random());
		push_cmd(KIND_LOAD, 10'(BLOCK_ROW), fill_word);

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			phase_regs = rand_regs();
			program_regs(phase_regs);
			calm = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(8, 30);
			for (int k = 0; k < phase_len; k++) begin
				roll = $urandom_range(0, 99);
				if (k < int'(phase_regs.row_count) && k < 16)
					push_cmd(KIND_LOAD, 10'(k), row_content());
				else if (roll < 45)
					push_cmd(KIND_SEARCH, 10'($urandom), wide_random());
				else if (roll < 85)
					push_cmd(KIND_LOAD, 10'($urandom_range(0, 31)), row_content());
				else
					push_cmd(KIND_LOAD, 10'($urandom), wide_random());
			end
			random_items += phase_len;
		end

		cmd_ch.valid <= 1'b0;
		calm = 1'b0;
		while (covers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && covers_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
